FILE: src/hsfc_pkg.sv
// Package: shared constants for the half/single float converter.
`default_nettype none
package hsfc_pkg;

  // Direction codes
  typedef enum logic {
    OP_HALF_TO_SINGLE = 1'b0,
    OP_SINGLE_TO_HALF = 1'b1
  } hsfc_op_t;

  localparam int unsigned HalfW   = 16;
  localparam int unsigned SingleW = 32;
  localparam int unsigned HManW   = 10;
  localparam int unsigned SManW   = 23;

  localparam logic [7:0]  SExpMax     = 8'hff;
  localparam logic [7:0]  SExpBias16  = 8'd112;  // single bias minus half bias
  localparam logic [7:0]  SExpSubBase = 8'd103;  // exponent of a half with lsb only
  localparam logic [7:0]  SExpNormLo  = 8'd113;
  localparam logic [7:0]  SExpOvf     = 8'd143;
  localparam logic [4:0]  HExpMax     = 5'h1f;
  localparam logic [14:0] HMagInf     = 15'h7c00;
  localparam logic [10:0] HHidden     = 11'h400;

endpackage
`default_nettype wire

FILE: src/hsfc_if.sv
// Interfaces: valid/ready channels for operand and converted words.
`default_nettype none
interface hsfc_in_if
  import hsfc_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [SingleW-1:0]   operand;

  modport source (output valid, output opcode, output operand, input ready);
  modport sink   (input valid, input opcode, input operand, output ready);
endinterface

interface hsfc_out_if
  import hsfc_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [SingleW-1:0]   converted;

  modport source (output valid, output converted, input ready);
  modport sink   (input valid, input converted, output ready);
endinterface
`default_nettype wire

FILE: src/half_single_float_converter.sv
// Top level: input register, conversion logic and output register.
`default_nettype none
// Converts IEEE 754 half to single (opcode 0, exact) or single to half
// (opcode 1, truncating; NaNs with payload only in the low 13 bits become
// infinities). A half operand uses bits 15..0; a half result sits in bits
// 15..0 with bits 31..16 zero. The accepting edge loads the input register;
// the result register then takes the output of the conversion logic when it
// is empty or its word is being taken, so a word waits in the input register
// while the output is blocked. One word
// is accepted every cycle while the output side takes words; the result
// register lets a new word enter while a finished result waits.
module half_single_float_converter
  import hsfc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  hsfc_in_if.sink      in_ch,
  hsfc_out_if.source   out_ch
);

  logic               s1_v_r, s1_v_nxt;
  logic               s1_op_r;
  logic [SingleW-1:0] s1_opd_r;
  logic               out_v_r, out_v_nxt;
  logic [SingleW-1:0] out_data_r, out_data_nxt;

  logic               out_ld;
  logic               in_acc;
  logic [SingleW-1:0] widened;
  logic [HalfW-1:0]   narrowed;

  hsfc_widen u_widen (
    .half_in    (s1_opd_r[HalfW-1:0]),
    .single_out (widened)
  );

  hsfc_narrow u_narrow (
    .single_in (s1_opd_r),
    .half_out  (narrowed)
  );

  assign out_ld       = !out_v_r || out_ch.ready;
  assign in_ch.ready  = !s1_v_r || out_ld;
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign out_data_nxt = (hsfc_op_t'(s1_op_r) == OP_SINGLE_TO_HALF)
                        ? {16'b0, narrowed} : widened;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (out_ld) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (out_ld) begin
      out_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r  <= in_ch.opcode;
      s1_opd_r <= in_ch.operand;
    end
    if (out_ld && s1_v_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.converted = out_data_r;

`ifndef SYNTHESIS
  // input only stalls when both registers hold words and output is blocked
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_v_r && out_v_r && !out_ch.ready))
    else $error("input stalled with room in pipeline");

  // a word in the input register moves to the output when it may
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_ld) |=> out_ch.valid)
    else $error("word lost between stages");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_ch.valid && !s1_v_r))
    else $error("pipeline not empty after reset");
`endif

endmodule
`default_nettype wire

FILE: src/hsfc_widen.sv
// Half to single widening: exact, subnormal halves renormalised.
`default_nettype none
module hsfc_widen
  import hsfc_pkg::*;
(
  input  wire logic [HalfW-1:0]   half_in,
  output logic      [SingleW-1:0] single_out
);

  logic              sgn;
  logic [4:0]        hexp;
  logic [HManW-1:0]  hman;
  logic [3:0]        top;
  logic [HManW-1:0]  norm_man;
  logic [3:0]        lshift;

  assign sgn  = half_in[15];
  assign hexp = half_in[14:10];
  assign hman = half_in[HManW-1:0];

  // leading-one position, 0..9
  always_comb begin
    top = '0;
    for (int p = 0; p < HManW; p++) begin
      if (hman[p]) top = 4'(p);
    end
  end

  assign lshift   = 4'(HManW) - top;
  assign norm_man = hman << lshift;   // hidden bit falls off the top

  always_comb begin
    if (hexp == '0) begin
      if (hman == '0) begin
        single_out = {sgn, 31'b0};
      end else begin
        single_out = {sgn, SExpSubBase + {4'b0, top}, norm_man, 13'b0};
      end
    end else if (hexp == HExpMax) begin
      single_out = {sgn, SExpMax, hman, 13'b0};
    end else begin
      single_out = {sgn, {3'b0, hexp} + SExpBias16, hman, 13'b0};
    end
  end

endmodule
`default_nettype wire

FILE: src/hsfc_narrow.sv
// Single to half narrowing: mantissa truncated, no rounding.
`default_nettype none
module hsfc_narrow
  import hsfc_pkg::*;
(
  input  wire logic [SingleW-1:0] single_in,
  output logic      [HalfW-1:0]   half_out
);

  logic              sgn;
  logic [7:0]        sexp;
  logic [SManW-1:0]  sman;
  logic [7:0]        sub_dist;
  logic [3:0]        sub_sh;
  logic [4:0]        man_sh;
  logic [10:0]       sub_hid;
  logic [SManW-1:0]  sub_man;
  logic [7:0]        norm_exp;
  logic [14:0]       mag;

  assign sgn  = single_in[31];
  assign sexp = single_in[30:23];
  assign sman = single_in[SManW-1:0];

  // only meaningful for exponents 103..112: distance 1..10
  assign sub_dist = SExpNormLo - sexp;
  assign sub_sh   = sub_dist[3:0];
  assign man_sh   = {1'b0, sub_sh} + 5'd13;
  assign sub_hid  = HHidden >> sub_sh;
  assign sub_man  = sman >> man_sh;
  assign norm_exp = sexp - SExpBias16;

  always_comb begin
    priority if (sexp < SExpSubBase) begin
      mag = '0;
    end else if (sexp < SExpNormLo) begin
      mag = {4'b0, sub_hid} | sub_man[14:0];
    end else if (sexp < SExpOvf) begin
      mag = {norm_exp[4:0], sman[22:13]};
    end else if (sexp < SExpMax) begin
      mag = HMagInf;
    end else begin
      // NaN keeps top payload bits only
      mag = HMagInf | {5'b0, sman[22:13]};
    end
  end

  assign half_out = {sgn, mag};

endmodule
`default_nettype wire

FILE: test/half_single_float_converter_tb.sv
// Testbench: random and directed half/single conversions checked against a local predictor.
`default_nettype none
module half_single_float_converter_tb
  import hsfc_pkg::*;
;

  localparam int unsigned HoldCycles = 200;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PhaseItems = 210;

  typedef struct {
    hsfc_op_t    op;
    logic [31:0] operand;
  } conv_word_t;

  typedef struct {
    conv_word_t  src;
    logic [31:0] converted;
  } conv_expect_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hsfc_in_if  in_ch ();
  hsfc_out_if out_ch ();

  half_single_float_converter u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  conv_word_t   pending_q[$];
  conv_expect_t expected_q[$];
  conv_word_t   next_w;
  conv_expect_t got_exp;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned phase = 0;
  logic        rx_hold = 1'b0;
  int unsigned n_errors = 0;
  int unsigned n_h2s = 0;
  int unsigned n_s2h = 0;
  int unsigned n_checked = 0;
  int unsigned stall_cnt = 0;

  always #2 clk = ~clk;

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Exact widening; subnormal halves are normalised
  function automatic logic [31:0] half_to_single_bits(input logic [15:0] h);
    logic       s;
    logic [4:0] e;
    logic [9:0] m;
    logic [9:0] norm;
    int         lead;
    s = h[15];
    e = h[14:10];
    m = h[9:0];
    if (e == 5'd0) begin
      if (m == 10'd0) return {s, 31'b0};
      lead = 0;
      for (int p = 0; p < 10; p++)
        if (m[p]) lead = p;
      norm = m << (10 - lead);
      return {s, 8'(103 + lead), norm, 13'b0};
    end
    if (e == 5'h1f) return {s, 8'hff, m, 13'b0};
    return {s, 8'(int'(e) + 112), m, 13'b0};
  endfunction

  // Truncating narrowing; result in the low 16 bits
  function automatic logic [31:0] single_to_half_bits(input logic [31:0] t);
    logic        s;
    logic [7:0]  e;
    logic [22:0] m;
    logic [14:0] mag;
    s = t[31];
    e = t[30:23];
    m = t[22:0];
    if (e < 8'd103)
      mag = 15'd0;
    else if (e < 8'd113)
      mag = 15'((32'h400 >> (113 - int'(e))) | (32'(m) >> (126 - int'(e))));
    else if (e < 8'd143)
      mag = {5'(int'(e) - 112), m[22:13]};
    else if (e < 8'hff)
      mag = 15'h7c00;
    else
      mag = 15'h7c00 | {5'd0, m[22:13]};
    return {16'b0, s, mag};
  endfunction

  function automatic logic [31:0] predict_converted(input conv_word_t w);
    if (w.op == OP_HALF_TO_SINGLE) return half_to_single_bits(w.operand[15:0]);
    return single_to_half_bits(w.operand);
  endfunction

  // Random word, biased towards the exponent classes that matter
  function automatic conv_word_t draw_operand();
    conv_word_t w;
    w.op = hsfc_op_t'($urandom_range(0, 1));
    w.operand = $urandom();
    if ($urandom_range(0, 9) == 0) return w;
    if (w.op == OP_HALF_TO_SINGLE) begin
      case ($urandom_range(0, 4))
        0: begin
          w.operand[14:10] = 5'd0;
          if ($urandom_range(0, 3) == 0) w.operand[9:0] = 10'd0;
          else if ($urandom_range(0, 2) == 0)
            w.operand[9:0] = 10'(1 << $urandom_range(0, 9));
        end
        1: begin
          w.operand[14:10] = 5'h1f;
          if ($urandom_range(0, 1) == 0) w.operand[9:0] = 10'd0;
        end
        default: begin
          w.operand[14:10] = 5'($urandom_range(1, 30));
        end
      endcase
    end else begin
      case ($urandom_range(0, 5))
        0: w.operand[30:23] = 8'($urandom_range(0, 102));
        1: w.operand[30:23] = 8'($urandom_range(103, 112));
        2, 3: w.operand[30:23] = 8'($urandom_range(113, 142));
        4: w.operand[30:23] = 8'($urandom_range(143, 254));
        default: begin
          w.operand[30:23] = 8'hff;
          // payload confined to the truncated bits
          if ($urandom_range(0, 2) == 0) w.operand[22:13] = 10'd0;
        end
      endcase
    end
    return w;
  endfunction

  function automatic conv_word_t mk_word(input hsfc_op_t op, input logic [31:0] v);
    conv_word_t w;
    w.op = op;
    w.operand = v;
    return w;
  endfunction

  task automatic report_mismatch(input string what, input conv_expect_t e,
                                 input logic [31:0] got);
    n_errors++;
    if (n_errors <= 20)
      $display("MISMATCH %s: op=%s operand=%08h want=%08h got=%08h",
               what, e.src.op.name(), e.src.operand, e.converted, got);
  endtask

  // Driver: record accepted words, then offer the next one
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      next_w = mk_word(hsfc_op_t'(in_ch.opcode), in_ch.operand);
      expected_q.push_back('{src: next_w, converted: predict_converted(next_w)});
      if (next_w.op == OP_HALF_TO_SINGLE) n_h2s++;
      else n_s2h++;
    end
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        next_w = pending_q.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.opcode  <= next_w.op;
        in_ch.operand <= next_w.operand;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: check results, then decide the next ready
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        got_exp = '{src: mk_word(OP_HALF_TO_SINGLE, 32'd0), converted: 32'd0};
        report_mismatch("unexpected word", got_exp, out_ch.converted);
      end else begin
        got_exp = expected_q.pop_front();
        n_checked++;
        if (out_ch.converted !== got_exp.converted)
          report_mismatch("converted", got_exp, out_ch.converted);
      end
    end
    if (!rst_n)
      out_ch.ready <= 1'b0;
    else
      out_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Watchdog: cycles with work outstanding but no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (pending_q.size() == 0 && expected_q.size() == 0 && !in_ch.valid)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("timeout after %0d cycles without progress", stall_cnt);
      $display("half_single_float_converter_tb: errors");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // Long receiver hold-off in the no-idle phase; the input side must back up
  initial begin
    wait (phase == 3);
    @(negedge clk);
    rx_hold = 1'b1;
    repeat (HoldCycles) @(negedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.opcode  = 1'b0;
    in_ch.operand = 32'd0;
    out_ch.ready  = 1'b0;

    wait (rst_n);
    @(negedge clk);
    tx_idle_pct = 33;
    rx_idle_pct = 56;
    phase = 1;
    // half to single: zeros, subnormal extremes, normals, infinities, NaNs, junk upper bits
    pending_q.push_back(mk_word(OP_HALF_TO_SINGLE, 32'h0000_0000));
    pending_q.push_back(mk_word(OP_HALF_TO_SINGLE, 32'h0000_8000));
    pending_q.push_back(mk_word(OP_HALF_TO_SINGLE, 32'h0000_0001));
    pending_q.push_back(mk_word(OP_HALF_TO_SINGLE, 32'h0000_83ff));
    pending_q.push_back(mk_word(OP_HALF_TO_SINGLE, 32'h0000_0400));
    pending_q.push_back(mk_word(OP_HALF_TO_SINGLE, 32'h0000_7bff));
    pending_q.push_back(mk_word(OP_HALF_TO_SINGLE, 32'h0000_7c00));
    pending_q.push_back(mk_word(OP_HALF_TO_SINGLE, 32'h0000_fc00));
    pending_q.push_back(mk_word(OP_HALF_TO_SINGLE, 32'h0000_7e00));
    pending_q.push_back(mk_word(OP_HALF_TO_SINGLE, 32'h0000_7c01));
    pending_q.push_back(mk_word(OP_HALF_TO_SINGLE, 32'hffff_3c00));
    // single to half: tiny, small, normal range edges, overflow, NaNs
    pending_q.push_back(mk_word(OP_SINGLE_TO_HALF, 32'h0000_0000));
    pending_q.push_back(mk_word(OP_SINGLE_TO_HALF, 32'h8000_0000));
    pending_q.push_back(mk_word(OP_SINGLE_TO_HALF, 32'h337f_ffff));
    pending_q.push_back(mk_word(OP_SINGLE_TO_HALF, 32'hb380_0000));
    pending_q.push_back(mk_word(OP_SINGLE_TO_HALF, 32'h387f_ffff));
    pending_q.push_back(mk_word(OP_SINGLE_TO_HALF, 32'h3880_0000));
    pending_q.push_back(mk_word(OP_SINGLE_TO_HALF, 32'h477f_ffff));
    pending_q.push_back(mk_word(OP_SINGLE_TO_HALF, 32'h4780_0000));
    pending_q.push_back(mk_word(OP_SINGLE_TO_HALF, 32'hc780_0000));
    pending_q.push_back(mk_word(OP_SINGLE_TO_HALF, 32'h7f7f_ffff));
    pending_q.push_back(mk_word(OP_SINGLE_TO_HALF, 32'h7f80_0000));
    pending_q.push_back(mk_word(OP_SINGLE_TO_HALF, 32'h7fc0_0000));
    pending_q.push_back(mk_word(OP_SINGLE_TO_HALF, 32'hff80_1fff));
    repeat (PhaseItems) pending_q.push_back(draw_operand());
    wait (pending_q.size() == 0 && expected_q.size() == 0 && !in_ch.valid);

    @(negedge clk);
    tx_idle_pct = 56;
    rx_idle_pct = 33;
    phase = 2;
    repeat (PhaseItems) pending_q.push_back(draw_operand());
    wait (pending_q.size() == 0 && expected_q.size() == 0 && !in_ch.valid);

    @(negedge clk);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    phase = 3;
    repeat (PhaseItems) pending_q.push_back(draw_operand());
    wait (pending_q.size() == 0 && expected_q.size() == 0 && !in_ch.valid && !rx_hold);

    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    $display("checked %0d words: %0d half-to-single, %0d single-to-half",
             n_checked, n_h2s, n_s2h);
    $display("three idle mixes plus a %0d-cycle output hold-off; %0d mismatches",
             HoldCycles, n_errors);
    if (n_errors == 0 && expected_q.size() == 0)
      $display("half_single_float_converter_tb: clean");
    else
      $display("half_single_float_converter_tb: errors");
    $finish;
  end

endmodule
`default_nettype wire
